/* sv/spc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constants for the steering PD controller.
package spc_pkg;

  localparam int GAIN_W     = 16;
  localparam int CENTER_W   = 7;
  localparam int GYRO_W     = 12;
  localparam int SUB_W      = 4;
  localparam int LIMIT_W    = 15;
  localparam int DRIVE_W    = 16;
  localparam int ERR_W      = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int STEPS_PER_PERIOD_DEF = 10;

  // Gain term is (gain * |v|) / 10 >> 8, i.e. floor(gain * |v| / 2560),
  // done as a shift by 9 followed by a divide by 5.
  localparam int TERM_SHIFT = 9;
  localparam int TERM_DIV   = 5;

  localparam logic KIND_CONTROL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  localparam logic signed [ERR_W-1:0] TARGET_MID   = 8'sd64;
  localparam logic signed [ERR_W-1:0] TARGET_RIGHT = 8'sd74;
  localparam logic signed [ERR_W-1:0] TARGET_LEFT  = 8'sd54;

  localparam logic [GYRO_W-1:0]  GYRO_ZERO_RST = 12'd2048;
  localparam logic [LIMIT_W-1:0] LIMIT_RST     = 15'h7FFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_DERIV_GAIN  = 3'd1,
    REG_RATE_GAIN   = 3'd2,
    REG_GYRO_ZERO   = 3'd3,
    REG_DERIV_LIMIT = 3'd4,
    REG_DRIVE_LIMIT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [GAIN_W-1:0]  rate_gain;
    logic [GYRO_W-1:0]  gyro_zero;
    logic [LIMIT_W-1:0] deriv_limit;
    logic [LIMIT_W-1:0] drive_limit;
  } cfg_t;

endpackage

/* sv/spc_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration register file: gains, gyro zero point and clamp limits.
module spc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [spc_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output spc_pkg::cfg_t                    cfg_o
);

  spc_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= '0;
      cfg_q.deriv_gain  <= '0;
      cfg_q.rate_gain   <= '0;
      cfg_q.gyro_zero   <= spc_pkg::GYRO_ZERO_RST;
      cfg_q.deriv_limit <= spc_pkg::LIMIT_RST;
      cfg_q.drive_limit <= spc_pkg::LIMIT_RST;
    end else if (cfg_valid_i) begin
      // keep only the register's width; drop writes past the last register
      case (spc_pkg::cfg_reg_e'(cfg_addr_i))
        spc_pkg::REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data_i;
        spc_pkg::REG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_data_i;
        spc_pkg::REG_RATE_GAIN:   cfg_q.rate_gain   <= cfg_data_i;
        spc_pkg::REG_GYRO_ZERO:   cfg_q.gyro_zero   <= cfg_data_i[spc_pkg::GYRO_W-1:0];
        spc_pkg::REG_DERIV_LIMIT: cfg_q.deriv_limit <= cfg_data_i[spc_pkg::LIMIT_W-1:0];
        spc_pkg::REG_DRIVE_LIMIT: cfg_q.drive_limit <= cfg_data_i[spc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/spc_gain_term.sv */
`timescale 1ns / 1ps
// Two-stage gain term: gain times |v|, then divide by 2560 truncating toward zero.
module spc_gain_term #(
  parameter int V_W = spc_pkg::ERR_W
) (
  input  logic                                   clk_i,
  input  logic                                   en1_i,
  input  logic                                   en2_i,
  input  logic [spc_pkg::GAIN_W-1:0]             gain_i,
  input  logic signed [V_W-1:0]                  val_i,
  output logic signed [V_W+spc_pkg::GAIN_W-spc_pkg::TERM_SHIFT-2:0] term_o
);

  localparam int P_W    = spc_pkg::GAIN_W + V_W;
  localparam int Y_W    = P_W - spc_pkg::TERM_SHIFT;
  // quotient of a divide by five fits two bits fewer
  localparam int T_W    = Y_W - 2;
  localparam int REC_SH = Y_W + 3;
  localparam int M_W    = Y_W + REC_SH;
  localparam logic [REC_SH-1:0] RECIP =
    REC_SH'(((64'd1 << REC_SH) + spc_pkg::TERM_DIV - 1) / spc_pkg::TERM_DIV);

  logic [V_W-1:0] mag;
  logic [P_W-1:0] prod_q;
  logic           neg1_q;
  logic [Y_W-1:0] y;
  logic [M_W-1:0] quo_full;
  logic [T_W-1:0] t_q;
  logic           neg2_q;

  // most negative value wraps to its own magnitude as unsigned
  assign mag = val_i[V_W-1] ? (V_W'(~val_i) + V_W'(1)) : V_W'(val_i);

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      prod_q <= P_W'(gain_i) * P_W'(mag);
      neg1_q <= val_i[V_W-1];
    end
  end

  // floor(y / 5) by reciprocal multiply, exact over the full range of y
  assign y        = prod_q[P_W-1:spc_pkg::TERM_SHIFT];
  assign quo_full = M_W'(y) * M_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      t_q    <= quo_full[REC_SH+T_W-1:REC_SH];
      neg2_q <= neg1_q;
    end
  end

  assign term_o = neg2_q ? -signed'({1'b0, t_q}) : signed'({1'b0, t_q});

endmodule

/* sv/spc_smoother.sv */
`timescale 1ns / 1ps
// Two-stage sub-period interpolation from the previous drive to the new one.
module spc_smoother #(
  parameter int STEPS = spc_pkg::STEPS_PER_PERIOD_DEF
) (
  input  logic                               clk_i,
  input  logic                               en1_i,
  input  logic                               en2_i,
  input  logic                               tick_i,
  input  logic signed [spc_pkg::DRIVE_W-1:0] new_i,
  input  logic signed [spc_pkg::DRIVE_W-1:0] old_i,
  input  logic [$clog2(STEPS+1)-1:0]         k_i,
  output logic signed [spc_pkg::DRIVE_W-1:0] smooth_o
);

  localparam int K_W    = $clog2(STEPS + 1);
  localparam int D_W    = spc_pkg::DRIVE_W + 1;
  localparam int PM_W   = D_W + K_W;
  localparam int REC_SH = PM_W + K_W;
  localparam int M_W    = PM_W + REC_SH + 1;
  localparam logic [REC_SH:0] RECIP =
    (REC_SH + 1)'(((64'd1 << REC_SH) + STEPS - 1) / STEPS);

  logic signed [D_W-1:0]             diff;
  logic [D_W-1:0]                    dmag;
  logic [PM_W-1:0]                   pmag_q;
  logic                              neg_q;
  logic                              tick_q;
  logic signed [spc_pkg::DRIVE_W-1:0] old_q;
  logic [M_W-1:0]                    prod;
  logic [D_W-1:0]                    quo;
  logic signed [D_W:0]               step;
  logic signed [D_W:0]               sum;
  logic signed [spc_pkg::DRIVE_W-1:0] smooth_q;

  assign diff = D_W'(new_i) - D_W'(old_i);
  assign dmag = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      pmag_q <= PM_W'(dmag) * PM_W'(k_i);
      neg_q  <= diff[D_W-1];
      tick_q <= tick_i;
      old_q  <= old_i;
    end
  end

  // truncate toward zero: divide the magnitude, then restore the sign
  assign prod = M_W'(pmag_q) * M_W'(RECIP);
  assign quo  = prod[REC_SH+D_W-1:REC_SH];
  assign step = neg_q ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
  assign sum  = (D_W + 1)'(old_q) + step;

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      smooth_q <= tick_q ? sum[spc_pkg::DRIVE_W-1:0] : '0;
    end
  end

  assign smooth_o = smooth_q;

endmodule

/* sv/steering_pd_controller.sv */
`timescale 1ns / 1ps
// Steering PD controller top level: input stage, error, drive sum and clamps.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------------------------
//   input    | in        | in_valid_i/in_ready_o  | kind, line_center, gyro_sample,
//            |           |                        | right_obstacle, left_obstacle, sub_period
//   result   | out       | out_valid_o/out_ready_i| drive_value, smoothed_drive
//   config   | in        | cfg_valid_i/cfg_ready_o| cfg_addr_i (index), cfg_data_i
//
// One word is accepted per cycle unless a stalled result backs up to the input.
// Five stages: input register, gain products, reciprocal divide, drive sum/clamp and
// interpolation product, interpolation divide into the result register.
// Drive state updates when a control word leaves the third stage; a tick reads it there.
// Reset loads register defaults and clears error and drive state; no clearing pass.
// A stalled result holds the last stage; earlier stages keep filling bubbles behind it.
module steering_pd_controller #(
  parameter int STEPS_PER_PERIOD = spc_pkg::STEPS_PER_PERIOD_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic [spc_pkg::CENTER_W-1:0]       line_center_i,
  input  logic [spc_pkg::GYRO_W-1:0]         gyro_sample_i,
  input  logic                               right_obstacle_i,
  input  logic                               left_obstacle_i,
  input  logic [spc_pkg::SUB_W-1:0]          sub_period_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [spc_pkg::DRIVE_W-1:0] drive_value_o,
  output logic signed [spc_pkg::DRIVE_W-1:0] smoothed_drive_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [spc_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [spc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int K_W    = $clog2(STEPS_PER_PERIOD + 1);
  localparam int IW     = (spc_pkg::SUB_W + 1 > K_W) ? spc_pkg::SUB_W + 1 : K_W;
  localparam int DER_W  = spc_pkg::ERR_W + 1;
  localparam int RATE_W = spc_pkg::GYRO_W + 1;
  localparam int TOFF   = spc_pkg::GAIN_W - spc_pkg::TERM_SHIFT - 2;
  localparam int SUM_W  = RATE_W + TOFF + 3;

  spc_pkg::cfg_t cfg;

  // pipeline valid bits and per-stage load enables
  logic s0_valid_q, s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic acc0, acc1, acc2, acc3, acc4;

  logic                          s0_kind_q;
  logic [spc_pkg::CENTER_W-1:0]  s0_center_q;
  logic [spc_pkg::GYRO_W-1:0]    s0_gyro_q;
  logic                          s0_right_q;
  logic                          s0_left_q;
  logic [spc_pkg::SUB_W-1:0]     s0_sub_q;

  logic s1_kind_q, s2_kind_q, s3_kind_q, s4_kind_q;
  logic [K_W-1:0] s1_k_q, s2_k_q;

  logic signed [spc_pkg::ERR_W-1:0] target;
  logic signed [spc_pkg::ERR_W-1:0] err;
  logic signed [DER_W-1:0]          derr;
  logic signed [RATE_W-1:0]         rate_v;
  logic [IW-1:0]                    idx_ext;
  logic [K_W-1:0]                   k;

  logic signed [spc_pkg::ERR_W-1:0] last_error_q;
  logic signed [spc_pkg::DRIVE_W-1:0] new_drive_q, old_drive_q;
  logic err_we, drv_we;

  logic signed [spc_pkg::ERR_W+TOFF:0] p_term;
  logic signed [DER_W+TOFF:0]          d_term;
  logic signed [RATE_W+TOFF:0]         r_term;

  logic signed [SUM_W-1:0] d_ext, d_lim, d_cl;
  logic signed [SUM_W-1:0] sum, drv_lim, drv_cl;
  logic signed [spc_pkg::DRIVE_W-1:0] new_val;

  logic signed [spc_pkg::DRIVE_W-1:0] s3_drive_q, s4_drive_q;
  logic signed [spc_pkg::DRIVE_W-1:0] smooth;

  spc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign acc4 = !s4_valid_q || out_ready_i;
  assign acc3 = !s3_valid_q || acc4;
  assign acc2 = !s2_valid_q || acc3;
  assign acc1 = !s1_valid_q || acc2;
  assign acc0 = !s0_valid_q || acc1;
  assign in_ready_o = acc0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (acc0) s0_valid_q <= in_valid_i;
      if (acc1) s1_valid_q <= s0_valid_q;
      if (acc2) s2_valid_q <= s1_valid_q;
      if (acc3) s3_valid_q <= s2_valid_q;
      if (acc4) s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc0) begin
      s0_kind_q   <= kind_i;
      s0_center_q <= line_center_i;
      s0_gyro_q   <= gyro_sample_i;
      s0_right_q  <= right_obstacle_i;
      s0_left_q   <= left_obstacle_i;
      s0_sub_q    <= sub_period_i;
    end
  end

  // right obstacle wins when both flags are set
  assign target = s0_right_q ? spc_pkg::TARGET_RIGHT :
                  (s0_left_q ? spc_pkg::TARGET_LEFT : spc_pkg::TARGET_MID);
  assign err    = signed'({1'b0, s0_center_q}) - target;
  assign derr   = DER_W'(err) - DER_W'(last_error_q);
  assign rate_v = signed'({1'b0, cfg.gyro_zero}) - signed'({1'b0, s0_gyro_q});

  // saturate the tick index to the last step of the period
  assign idx_ext = IW'(s0_sub_q) + IW'(1);
  assign k       = (idx_ext > IW'(STEPS_PER_PERIOD)) ? K_W'(STEPS_PER_PERIOD)
                                                       : K_W'(idx_ext);

  assign err_we = acc1 && s0_valid_q && (s0_kind_q == spc_pkg::KIND_CONTROL);
  assign drv_we = acc3 && s2_valid_q && (s2_kind_q == spc_pkg::KIND_CONTROL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_error_q <= '0;
      new_drive_q  <= '0;
      old_drive_q  <= '0;
    end else begin
      if (err_we) last_error_q <= err;
      if (drv_we) begin
        old_drive_q <= new_drive_q;
        new_drive_q <= new_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc1) begin
      s1_kind_q <= s0_kind_q;
      s1_k_q    <= k;
    end
    if (acc2) begin
      s2_kind_q <= s1_kind_q;
      s2_k_q    <= s1_k_q;
    end
    if (acc3) begin
      s3_kind_q  <= s2_kind_q;
      s3_drive_q <= (s2_kind_q == spc_pkg::KIND_CONTROL) ? new_val : new_drive_q;
    end
    if (acc4) begin
      s4_kind_q  <= s3_kind_q;
      s4_drive_q <= s3_drive_q;
    end
  end

  spc_gain_term #(.V_W(spc_pkg::ERR_W)) u_prop (
    .clk_i  (clk_i),
    .en1_i  (acc1),
    .en2_i  (acc2),
    .gain_i (cfg.prop_gain),
    .val_i  (err),
    .term_o (p_term)
  );

  spc_gain_term #(.V_W(DER_W)) u_deriv (
    .clk_i  (clk_i),
    .en1_i  (acc1),
    .en2_i  (acc2),
    .gain_i (cfg.deriv_gain),
    .val_i  (derr),
    .term_o (d_term)
  );

  spc_gain_term #(.V_W(RATE_W)) u_rate (
    .clk_i  (clk_i),
    .en1_i  (acc1),
    .en2_i  (acc2),
    .gain_i (cfg.rate_gain),
    .val_i  (rate_v),
    .term_o (r_term)
  );

  assign d_ext = SUM_W'(d_term);
  assign d_lim = SUM_W'(signed'({1'b0, cfg.deriv_limit}));
  assign d_cl  = (d_ext > d_lim) ? d_lim : ((d_ext < -d_lim) ? -d_lim : d_ext);

  assign sum     = SUM_W'(p_term) + d_cl + SUM_W'(r_term);
  assign drv_lim = SUM_W'(signed'({1'b0, cfg.drive_limit}));
  assign drv_cl  = (sum > drv_lim) ? drv_lim : ((sum < -drv_lim) ? -drv_lim : sum);
  assign new_val = drv_cl[spc_pkg::DRIVE_W-1:0];

  spc_smoother #(.STEPS(STEPS_PER_PERIOD)) u_smooth (
    .clk_i    (clk_i),
    .en1_i    (acc3),
    .en2_i    (acc4),
    .tick_i   (s2_kind_q == spc_pkg::KIND_TICK),
    .new_i    (new_drive_q),
    .old_i    (old_drive_q),
    .k_i      (s2_k_q),
    .smooth_o (smooth)
  );

  assign out_valid_o      = s4_valid_q;
  assign drive_value_o    = s4_drive_q;
  assign smoothed_drive_o = smooth;

`ifndef NO_ASSERTIONS
  a_ctrl_smooth_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (s4_kind_q == spc_pkg::KIND_CONTROL) |-> smoothed_drive_o == '0)
    else $error("control result carries a nonzero smoothed drive");

  a_ctrl_drive_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (s4_kind_q == spc_pkg::KIND_CONTROL) |->
      (SUM_W'(drive_value_o) <= drv_lim) && (SUM_W'(drive_value_o) >= -drv_lim))
    else $error("control drive outside the drive limit");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s0_valid_q && s1_valid_q && s2_valid_q && s3_valid_q && s4_valid_q)
    else $error("input stalled with a bubble in the pipeline");

  a_error_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_error_q != $past(last_error_q)) |-> $past(err_we))
    else $error("last error changed without a control word");

  a_drive_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (new_drive_q != $past(new_drive_q)) |-> $past(drv_we))
    else $error("drive state changed without a control word");
`endif

endmodule

/* verif/steering_pd_controller_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the steering PD controller: directed table, then random phases.
module steering_pd_controller_tb;

  localparam int STEPS           = spc_pkg::STEPS_PER_PERIOD_DEF;
  localparam int CENTER_W        = spc_pkg::CENTER_W;
  localparam int GYRO_W          = spc_pkg::GYRO_W;
  localparam int SUB_W           = spc_pkg::SUB_W;
  localparam int DRIVE_W         = spc_pkg::DRIVE_W;
  localparam int GAIN_W          = spc_pkg::GAIN_W;
  localparam int LIMIT_W         = spc_pkg::LIMIT_W;
  localparam int CFG_ADDR_W      = spc_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W      = spc_pkg::CFG_DATA_W;
  localparam int DRAIN_GAP       = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 2000;
  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 193;
  localparam int HOLD_PHASE      = 3;
  localparam int PAUSE_PHASE     = 5;

  // Indexes past the last register; the block must ignore writes to them.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                kind;
    logic [CENTER_W-1:0] center;
    logic [GYRO_W-1:0]   gyro;
    logic                right;
    logic                left;
    logic [SUB_W-1:0]    sub;
  } steer_word_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [DRIVE_W-1:0] smooth;
  } drive_pair_t;

  typedef struct {
    bit                    is_reg;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    steer_word_t           w;
    bit                    typed;
    int                    exp_drive;
    int                    exp_smooth;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic                        kind_i = spc_pkg::KIND_CONTROL;
  logic [CENTER_W-1:0]         line_center_i = '0;
  logic [GYRO_W-1:0]           gyro_sample_i = '0;
  logic                        right_obstacle_i = 1'b0;
  logic                        left_obstacle_i = 1'b0;
  logic [SUB_W-1:0]            sub_period_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [DRIVE_W-1:0]   drive_value_o;
  logic signed [DRIVE_W-1:0]   smoothed_drive_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_ADDR_W-1:0]       cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0]       cfg_data_i = '0;

  // Typed expectation travelling with the word on the input channel.
  logic                      typed_chk = 1'b0;
  logic signed [DRIVE_W-1:0] typed_drive = '0;
  logic signed [DRIVE_W-1:0] typed_smooth = '0;

  steering_pd_controller DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .line_center_i    (line_center_i),
    .gyro_sample_i    (gyro_sample_i),
    .right_obstacle_i (right_obstacle_i),
    .left_obstacle_i  (left_obstacle_i),
    .sub_period_i     (sub_period_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_value_o    (drive_value_o),
    .smoothed_drive_o (smoothed_drive_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the controller registers and state.
  spc_pkg::cfg_t reg_shadow;
  longint        track_err;
  longint        drive_now;
  longint        drive_prev;

  drive_pair_t pending_drive[$];
  plan_row_t   plan_q[$];
  int          mismatches = 0;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit cfg_busy = 1'b0;
  int gap_pct = 20;
  int sink_busy_pct = 20;

  function automatic longint scaled_term(input logic [GAIN_W-1:0] gain, input longint v);
    longint mag;
    longint t;
    mag = (v < 0) ? -v : v;
    t = (longint'(gain) * mag) / 10;
    t = t >>> 8;
    return (v < 0) ? -t : t;
  endfunction

  function automatic longint clip(input longint x, input logic [LIMIT_W-1:0] lim);
    if (x > longint'(lim)) return longint'(lim);
    if (x < -longint'(lim)) return -longint'(lim);
    return x;
  endfunction

  function automatic drive_pair_t next_drive(input steer_word_t w);
    longint tgt;
    longint err;
    longint p;
    longint d;
    longint r;
    longint idx;
    drive_pair_t res;
    res.smooth = '0;
    if (w.kind == spc_pkg::KIND_CONTROL) begin
      // right flag wins when both are set
      tgt = w.right ? longint'(spc_pkg::TARGET_RIGHT)
                    : (w.left ? longint'(spc_pkg::TARGET_LEFT)
                              : longint'(spc_pkg::TARGET_MID));
      err = longint'(w.center) - tgt;
      p = scaled_term(reg_shadow.prop_gain, err);
      d = clip(scaled_term(reg_shadow.deriv_gain, err - track_err), reg_shadow.deriv_limit);
      r = scaled_term(reg_shadow.rate_gain,
                      longint'(reg_shadow.gyro_zero) - longint'(w.gyro));
      drive_prev = drive_now;
      drive_now = clip(p + d + r, reg_shadow.drive_limit);
      track_err = err;
    end else begin
      idx = (longint'(w.sub) >= STEPS) ? STEPS - 1 : longint'(w.sub);
      res.smooth = DRIVE_W'(drive_prev + ((drive_now - drive_prev) * (idx + 1)) / STEPS);
    end
    res.drive = DRIVE_W'(drive_now);
    return res;
  endfunction

  function automatic void apply_reg(input logic [CFG_ADDR_W-1:0] addr,
                                    input logic [CFG_DATA_W-1:0] data);
    case (addr)
      spc_pkg::REG_PROP_GAIN:   reg_shadow.prop_gain = data;
      spc_pkg::REG_DERIV_GAIN:  reg_shadow.deriv_gain = data;
      spc_pkg::REG_RATE_GAIN:   reg_shadow.rate_gain = data;
      spc_pkg::REG_GYRO_ZERO:   reg_shadow.gyro_zero = data[GYRO_W-1:0];
      spc_pkg::REG_DERIV_LIMIT: reg_shadow.deriv_limit = data[LIMIT_W-1:0];
      spc_pkg::REG_DRIVE_LIMIT: reg_shadow.drive_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  initial begin
    reg_shadow.prop_gain   = '0;
    reg_shadow.deriv_gain  = '0;
    reg_shadow.rate_gain   = '0;
    reg_shadow.gyro_zero   = spc_pkg::GYRO_ZERO_RST;
    reg_shadow.deriv_limit = spc_pkg::LIMIT_RST;
    reg_shadow.drive_limit = spc_pkg::LIMIT_RST;
    track_err  = 0;
    drive_now  = 0;
    drive_prev = 0;
  end

  always @(posedge clk_i) begin : check_drive
    steer_word_t seen;
    drive_pair_t got;
    drive_pair_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_addr_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        seen.kind   = kind_i;
        seen.center = line_center_i;
        seen.gyro   = gyro_sample_i;
        seen.right  = right_obstacle_i;
        seen.left   = left_obstacle_i;
        seen.sub    = sub_period_i;
        got = next_drive(seen);
        if (typed_chk) begin
          got.drive  = typed_drive;
          got.smooth = typed_smooth;
        end
        pending_drive.push_back(got);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_drive.size() == 0) begin
          $error("result word with nothing expected: drive_value %0d, smoothed_drive %0d",
                 drive_value_o, smoothed_drive_o);
          mismatches++;
        end else begin
          want = pending_drive.pop_front();
          if (drive_value_o !== want.drive) begin
            $error("drive_value mismatch: expected %0d, actual %0d", want.drive, drive_value_o);
            mismatches++;
          end
          if (smoothed_drive_o !== want.smooth) begin
            $error("smoothed_drive mismatch: expected %0d, actual %0d",
                   want.smooth, smoothed_drive_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Result side: random ready bursts, one long hold on request, always ready when calm.
  initial begin : sink
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < sink_busy_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Drop valid, wait for every expected word, then let the pipeline settle.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    if (!cfg_busy) begin
      quiesce();
      cfg_busy = 1'b1;
    end
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Return at the accept edge with valid still high.
  task automatic send_word(input steer_word_t w, input bit typed, input int ed, input int es);
    if (cfg_busy) begin
      cfg_valid_i <= 1'b0;
      cfg_busy = 1'b0;
    end
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= w.kind;
    line_center_i    <= w.center;
    gyro_sample_i    <= w.gyro;
    right_obstacle_i <= w.right;
    left_obstacle_i  <= w.left;
    sub_period_i     <= w.sub;
    typed_chk        <= typed;
    typed_drive      <= DRIVE_W'(ed);
    typed_smooth     <= DRIVE_W'(es);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic void add_word(input logic kind, input int center, input int gyro,
                                   input bit right, input bit left, input int sub,
                                   input bit typed, input int ed, input int es);
    plan_row_t row;
    row.is_reg     = 1'b0;
    row.addr       = '0;
    row.data       = '0;
    row.w.kind     = kind;
    row.w.center   = CENTER_W'(center);
    row.w.gyro     = GYRO_W'(gyro);
    row.w.right    = right;
    row.w.left     = left;
    row.w.sub      = SUB_W'(sub);
    row.typed      = typed;
    row.exp_drive  = ed;
    row.exp_smooth = es;
    plan_q.push_back(row);
  endfunction

  function automatic void add_reg(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.addr   = addr;
    row.data   = data;
    plan_q.push_back(row);
  endfunction

  initial begin : stimulus
    steer_word_t           w;
    spc_pkg::cfg_reg_e     r;
    logic [CFG_DATA_W-1:0] val;

    //       kind                   ctr   gyro  R  L  sub typed drive  smooth
    // all gains zero after reset
    add_word(spc_pkg::KIND_CONTROL, 127, 4095, 1, 1, 15, 1,     0,     0);
    add_word(spc_pkg::KIND_TICK,      0,    0, 0, 0,  0, 1,     0,     0);
    // full proportional gain against a tight drive clamp
    add_reg(spc_pkg::REG_PROP_GAIN,   16'hFFFF);
    add_reg(spc_pkg::REG_DRIVE_LIMIT, 16'd1000);
    add_word(spc_pkg::KIND_CONTROL, 127, 2048, 0, 0,  0, 1,  1000,     0);
    add_word(spc_pkg::KIND_CONTROL,   0, 2048, 0, 0,  0, 1, -1000,     0);
    add_word(spc_pkg::KIND_TICK,     64,  100, 1, 0, 15, 1, -1000, -1000);
    add_word(spc_pkg::KIND_TICK,     64,  100, 0, 1,  0, 1, -1000,   800);
    add_word(spc_pkg::KIND_TICK,     64,  100, 0, 0,  9, 1, -1000, -1000);
    add_word(spc_pkg::KIND_TICK,     64,  100, 0, 0, 10, 1, -1000, -1000);
    // all gains at max, derivative clamped off, junk in the upper data bits
    add_reg(spc_pkg::REG_DERIV_GAIN,  16'hFFFF);
    add_reg(spc_pkg::REG_RATE_GAIN,   16'hFFFF);
    add_reg(spc_pkg::REG_GYRO_ZERO,   16'hFFFF);
    add_reg(spc_pkg::REG_DERIV_LIMIT, 16'h0000);
    add_reg(spc_pkg::REG_DRIVE_LIMIT, 16'hFFFF);
    add_reg(REG_SPARE_LO,             16'hFFFF);
    add_reg(REG_SPARE_HI,             16'h1234);
    add_word(spc_pkg::KIND_CONTROL,  64,    0, 1, 1,  0, 0, 0, 0);
    add_word(spc_pkg::KIND_CONTROL,  54, 4095, 0, 1,  0, 0, 0, 0);
    add_word(spc_pkg::KIND_CONTROL,  74, 2048, 1, 0,  0, 0, 0, 0);
    add_word(spc_pkg::KIND_CONTROL, 127, 4095, 0, 0,  0, 0, 0, 0);
    add_word(spc_pkg::KIND_CONTROL,   0,    0, 0, 0,  0, 0, 0, 0);
    add_word(spc_pkg::KIND_TICK,     10,   20, 0, 0,  5, 0, 0, 0);
    // zero drive clamp pins every output to zero
    add_reg(spc_pkg::REG_DRIVE_LIMIT, 16'h0000);
    add_reg(spc_pkg::REG_DERIV_LIMIT, 16'h7FFF);
    add_reg(spc_pkg::REG_GYRO_ZERO,   16'h0000);
    add_word(spc_pkg::KIND_CONTROL, 127, 4095, 0, 0,  0, 1,     0,     0);
    add_word(spc_pkg::KIND_CONTROL,   0,    0, 1, 0,  0, 1,     0,     0);
    add_word(spc_pkg::KIND_TICK,    127, 4095, 1, 1,  3, 1,     0,     0);
    // moderate gains, derivative clamp active
    add_reg(spc_pkg::REG_PROP_GAIN,   16'd300);
    add_reg(spc_pkg::REG_DERIV_GAIN,  16'd40000);
    add_reg(spc_pkg::REG_RATE_GAIN,   16'd100);
    add_reg(spc_pkg::REG_DERIV_LIMIT, 16'd200);
    add_reg(spc_pkg::REG_DRIVE_LIMIT, 16'h7FFF);
    add_reg(spc_pkg::REG_GYRO_ZERO,   16'd2048);
    add_word(spc_pkg::KIND_CONTROL,  60, 1800, 0, 0,  0, 0, 0, 0);
    add_word(spc_pkg::KIND_CONTROL,  80, 2300, 0, 1,  0, 0, 0, 0);
    add_word(spc_pkg::KIND_CONTROL,  30, 3000, 1, 0,  0, 0, 0, 0);
    add_word(spc_pkg::KIND_TICK,      5,    7, 0, 0,  4, 0, 0, 0);
    add_word(spc_pkg::KIND_TICK,      5,    7, 0, 0, 12, 0, 0, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_reg)
        put_reg(plan_q[i].addr, plan_q[i].data);
      else
        send_word(plan_q[i].w, plan_q[i].typed, plan_q[i].exp_drive, plan_q[i].exp_smooth);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      calm = (ph == N_PHASES - 1);
      gap_pct = 20 * $urandom_range(0, 2);
      sink_busy_pct = 20 * $urandom_range(0, 2);
      r = r.first();
      repeat (r.num()) begin
        if (ph == 0 || $urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 4))
            0: val = '0;
            1: val = '1;
            2: val = CFG_DATA_W'($urandom_range(0, 600));
            default: val = CFG_DATA_W'($urandom());
          endcase
          put_reg(r, val);
        end
        r = r.next();
      end
      if ($urandom_range(0, 3) == 0)
        put_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom()));
      // stall the result side so the pipeline fills and backs up the input
      if (ph == HOLD_PHASE) hold_req = 1'b1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) quiesce();
        w.kind   = ($urandom_range(0, 99) < 40) ? spc_pkg::KIND_TICK : spc_pkg::KIND_CONTROL;
        w.center = ($urandom_range(0, 3) == 0) ? CENTER_W'($urandom_range(50, 78))
                                                : CENTER_W'($urandom());
        w.gyro   = ($urandom_range(0, 1) == 0) ? GYRO_W'($urandom())
                                                : GYRO_W'(reg_shadow.gyro_zero
                                                          + $urandom_range(0, 64) - 32);
        w.right  = ($urandom_range(0, 3) == 0);
        w.left   = ($urandom_range(0, 3) == 0);
        w.sub    = ($urandom_range(0, 4) == 0) ? SUB_W'($urandom())
                                                : SUB_W'($urandom_range(0, STEPS - 1));
        send_word(w, 1'b0, 0, 0);
      end
    end

    quiesce();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
